### hdl/page_framebuffer_draw_engine_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the page framebuffer draw engine.
// Each macro expands to one labeled concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAMEBUFFER_DRAW_ENGINE_ASSERT_SVH
`define PAGE_FRAMEBUFFER_DRAW_ENGINE_ASSERT_SVH

// Next-cycle implication, disabled while reset is high.
`define PFDE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("draw engine assertion failed");

// Next-cycle implication that also holds while reset is high.
`define PFDE_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("draw engine assertion failed");

`endif

### hdl/pfde_pkg.sv
// ----------------------------------------------------------------------------
// pfde_pkg
// Shared constants, operation codes and bundle types of the draw engine.
// ----------------------------------------------------------------------------
package pfde_pkg;

  localparam int MaxWidth   = 256;
  localparam int MaxHeight  = 128;
  localparam int PageRows   = 8;
  localparam int PageCount  = (MaxHeight + PageRows - 1) / PageRows;
  localparam int StoreDepth = MaxWidth * PageCount;
  localparam int AddrBits   = $clog2(StoreDepth);
  localparam int PageBits   = $clog2(PageCount);
  localparam int XBits      = $clog2(MaxWidth);
  localparam int YBits      = $clog2(MaxHeight);

  localparam int OpBits     = 3;
  localparam int PosXBits   = 9;
  localparam int PosYBits   = 8;
  localparam int CountBits  = 16;
  localparam int DataBits   = 8;
  localparam int RegIdxBits = 1;

  localparam logic [OpBits-1:0] OP_SET_WINDOW  = 3'd0;
  localparam logic [OpBits-1:0] OP_SET_START   = 3'd1;
  localparam logic [OpBits-1:0] OP_FILL_WINDOW = 3'd2;
  localparam logic [OpBits-1:0] OP_DRAW_PIXEL  = 3'd3;
  localparam logic [OpBits-1:0] OP_FILL_RECT   = 3'd4;
  localparam logic [OpBits-1:0] OP_READ_BYTE   = 3'd5;

  localparam logic [RegIdxBits-1:0] REG_PANEL_WIDTH  = 1'd0;
  localparam logic [RegIdxBits-1:0] REG_PANEL_HEIGHT = 1'd1;

  typedef struct packed {
    logic [PosXBits-1:0] width;
    logic [PosYBits-1:0] height;
  } pan_t;

  typedef struct packed {
    logic                rd_en;
    logic [AddrBits-1:0] rd_addr;
    logic                wr_en;
    logic [AddrBits-1:0] wr_addr;
    logic [DataBits-1:0] wr_data;
  } mem_req_t;

  typedef struct packed {
    logic [DataBits-1:0]  read_byte;
    logic [CountBits-1:0] update_count;
  } res_t;

endpackage

### hdl/pfde_store.sv
// ----------------------------------------------------------------------------
// pfde_store
// Page-organized frame store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pfde_store (
  input  logic                        clk,
  input  pfde_pkg::mem_req_t          req,
  output logic [pfde_pkg::DataBits-1:0] rd_data
);
  import pfde_pkg::*;

  logic [DataBits-1:0] mem [StoreDepth];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

### hdl/pfde_seq.sv
// ----------------------------------------------------------------------------
// pfde_seq
// Operation sequencer: window and cursor state, read-modify-write of page
// bytes, clearing pass after reset and the update counter.
// ----------------------------------------------------------------------------
module pfde_seq (
  input  logic                           clk,
  input  logic                           rst,
  input  pfde_pkg::pan_t                 pan,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [pfde_pkg::OpBits-1:0]    operation,
  input  logic [pfde_pkg::PosXBits-1:0]  pos_x,
  input  logic [pfde_pkg::PosYBits-1:0]  pos_y,
  input  logic [pfde_pkg::PosXBits-1:0]  size_w,
  input  logic [pfde_pkg::PosYBits-1:0]  size_h,
  input  logic                           pixel_color,
  input  logic [pfde_pkg::CountBits-1:0] pixel_count,
  output logic                           res_valid,
  input  logic                           res_ready,
  output pfde_pkg::res_t                 res,
  output pfde_pkg::mem_req_t             mem_req,
  input  logic [pfde_pkg::DataBits-1:0]  mem_rd_data
);
  import pfde_pkg::*;

  localparam int SumBits = AddrBits + 2;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_PREP   = 6'b000100,
    S_ISSUE  = 6'b001000,
    S_MODIFY = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  function automatic logic [DataBits-1:0] row_mask(input logic [PosYBits-1:0] row,
                                                   input logic [PosYBits-1:0] end_row);
    logic [PosYBits:0] page_end;
    logic [3:0]        last;
    page_end = {1'b0, row[PosYBits-1:3], 3'b000} + (PosYBits+1)'(PageRows);
    last     = ({1'b0, end_row} >= page_end) ? 4'(PageRows) : {1'b0, end_row[2:0]};
    row_mask = (8'hFF << row[2:0]) & ~(8'hFF << last);
  endfunction

  state_t state;

  logic [OpBits-1:0]    op;
  logic [PosXBits-1:0]  px;
  logic [PosYBits-1:0]  py;
  logic [PosXBits-1:0]  sw;
  logic [PosYBits-1:0]  sh;
  logic                 color;
  logic [CountBits-1:0] remaining;

  logic [XBits-1:0]     win_left;
  logic [YBits-1:0]     win_top;
  logic [XBits-1:0]     win_right;
  logic [YBits-1:0]     win_bottom;
  logic [XBits-1:0]     cursor_x;
  logic [YBits-1:0]     cursor_y;
  logic [CountBits-1:0] draw_counter;

  logic [AddrBits-1:0]  clear_addr;
  logic [PosXBits-1:0]  rect_col;
  logic [PosYBits-1:0]  rect_row;
  logic [PosXBits-1:0]  end_x;
  logic [PosYBits-1:0]  end_y;
  logic [DataBits-1:0]  rect_mask;

  logic [AddrBits-1:0]  addr;
  logic [DataBits-1:0]  mask;
  logic                 do_write;
  logic [DataBits-1:0]  rd_byte;

  // Window and rectangle setup.
  logic [PosXBits-1:0] w_max;
  logic [PosYBits-1:0] h_max;
  logic [PosXBits-1:0] start_x;
  logic [PosYBits-1:0] start_y;
  logic [PosXBits:0]   right_full;
  logic [PosYBits:0]   bottom_full;
  logic [PosXBits-1:0] right_clip;
  logic [PosYBits-1:0] bottom_clip;
  logic [PosXBits:0]   rect_ex;
  logic [PosYBits:0]   rect_ey;
  logic                rect_abort;
  logic [PosXBits-1:0] clip_ex;
  logic [PosYBits-1:0] clip_ey;
  logic                rect_empty;
  logic                xy_in_panel;

  // Current pixel or byte.
  logic [PosXBits-1:0] cur_col;
  logic [PosYBits-1:0] cur_row;
  logic [PageBits-1:0] cur_page;
  logic [SumBits-1:0]  cur_sum;
  logic [DataBits-1:0] cur_mask;
  logic                cur_in_panel;

  // Advance after a byte.
  logic [XBits:0]      cx_inc;
  logic [YBits:0]      cy_inc;
  logic [PosXBits-1:0] col_inc;
  logic [PosYBits-1:0] row_next;
  logic [DataBits-1:0] wr_byte;

  always_comb begin
    w_max       = pan.width - PosXBits'(1);
    h_max       = pan.height - PosYBits'(1);
    start_x     = (px > w_max) ? w_max : px;
    start_y     = (py > h_max) ? h_max : py;
    right_full  = (sw == '0) ? {1'b0, start_x} : {1'b0, start_x} + {1'b0, sw} - 1'b1;
    bottom_full = (sh == '0) ? {1'b0, start_y} : {1'b0, start_y} + {1'b0, sh} - 1'b1;
    right_clip  = (right_full > {1'b0, w_max}) ? w_max : right_full[PosXBits-1:0];
    bottom_clip = (bottom_full > {1'b0, h_max}) ? h_max : bottom_full[PosYBits-1:0];

    rect_ex    = {1'b0, px} + {1'b0, sw};
    rect_ey    = {1'b0, py} + {1'b0, sh};
    rect_abort = ((rect_ex > {1'b0, pan.width}) && (px > pan.width)) ||
                 ((rect_ey > {1'b0, pan.height}) && (py > pan.height));
    clip_ex    = (rect_ex > {1'b0, pan.width}) ? pan.width : rect_ex[PosXBits-1:0];
    clip_ey    = (rect_ey > {1'b0, pan.height}) ? pan.height : rect_ey[PosYBits-1:0];
    rect_empty = (px >= clip_ex) || (py >= clip_ey);
    xy_in_panel = (px < pan.width) && (py < pan.height);
  end

  always_comb begin
    case (op)
      OP_FILL_WINDOW: begin
        cur_col = PosXBits'(cursor_x);
        cur_row = PosYBits'(cursor_y);
      end
      OP_FILL_RECT: begin
        cur_col = rect_col;
        cur_row = rect_row;
      end
      default: begin
        cur_col = px;
        cur_row = py;
      end
    endcase
    cur_page     = cur_row[PageBits+2:3];
    cur_sum      = SumBits'(pan.width) * SumBits'(cur_page) + SumBits'(cur_col);
    cur_mask     = (op == OP_FILL_RECT) ? rect_mask : (8'h01 << cur_row[2:0]);
    cur_in_panel = (cur_col < pan.width) && (cur_row < pan.height);

    cx_inc   = {1'b0, cursor_x} + 1'b1;
    cy_inc   = {1'b0, cursor_y} + 1'b1;
    col_inc  = rect_col + 1'b1;
    row_next = {rect_row[PosYBits-1:3], 3'b000} + PosYBits'(PageRows);
    wr_byte  = color ? (mem_rd_data | mask) : (mem_rd_data & ~mask);
  end

  always_comb begin
    mem_req = '0;
    unique case (state)
      S_CLEAR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = clear_addr;
        mem_req.wr_data = '0;
      end
      S_ISSUE: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = cur_sum[AddrBits-1:0];
      end
      S_MODIFY: begin
        mem_req.wr_en   = do_write;
        mem_req.wr_addr = addr;
        mem_req.wr_data = wr_byte;
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  assign in_ready         = (state == S_IDLE);
  assign res_valid        = (state == S_DONE);
  assign res.read_byte    = rd_byte;
  assign res.update_count = draw_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clear_addr   <= '0;
      win_left     <= '0;
      win_top      <= '0;
      win_right    <= '0;
      win_bottom   <= '0;
      cursor_x     <= '0;
      cursor_y     <= '0;
      draw_counter <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clear_addr <= clear_addr + 1'b1;
          if (clear_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op      <= operation;
            px      <= pos_x;
            py      <= pos_y;
            sw      <= size_w;
            sh      <= size_h;
            color   <= pixel_color;
            rd_byte <= '0;
            state   <= S_PREP;
            remaining <= pixel_count;
          end
        end
        S_PREP: begin
          case (op) inside
            OP_SET_WINDOW, OP_SET_START: begin
              win_left <= start_x[XBits-1:0];
              win_top  <= start_y[YBits-1:0];
              cursor_x <= start_x[XBits-1:0];
              cursor_y <= start_y[YBits-1:0];
              if (op == OP_SET_WINDOW) begin
                win_right  <= right_clip[XBits-1:0];
                win_bottom <= bottom_clip[YBits-1:0];
              end
              state <= S_DONE;
            end
            OP_FILL_WINDOW: begin
              if (remaining == '0) begin
                draw_counter <= draw_counter + 1'b1;
                state        <= S_DONE;
              end else begin
                state <= S_ISSUE;
              end
            end
            OP_DRAW_PIXEL, OP_READ_BYTE: begin
              state <= xy_in_panel ? S_ISSUE : S_DONE;
            end
            OP_FILL_RECT: begin
              if (!rect_abort && !rect_empty) begin
                rect_col  <= px;
                rect_row  <= py;
                end_x     <= clip_ex;
                end_y     <= clip_ey;
                rect_mask <= row_mask(py, clip_ey);
                state     <= S_ISSUE;
              end else begin
                if (!rect_abort) begin
                  draw_counter <= draw_counter + 1'b1;
                end
                state <= S_DONE;
              end
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_ISSUE: begin
          addr     <= cur_sum[AddrBits-1:0];
          mask     <= cur_mask;
          do_write <= cur_in_panel && (op != OP_READ_BYTE);
          state    <= S_MODIFY;
        end
        S_MODIFY: begin
          case (op)
            OP_READ_BYTE: begin
              rd_byte <= mem_rd_data;
              state   <= S_DONE;
            end
            OP_DRAW_PIXEL: begin
              draw_counter <= draw_counter + 1'b1;
              state        <= S_DONE;
            end
            OP_FILL_WINDOW: begin
              remaining <= remaining - 1'b1;
              if (cx_inc > {1'b0, win_right}) begin
                cursor_x <= win_left;
                cursor_y <= (cy_inc > {1'b0, win_bottom}) ? win_top : cy_inc[YBits-1:0];
              end else begin
                cursor_x <= cx_inc[XBits-1:0];
              end
              if (remaining == CountBits'(1)) begin
                draw_counter <= draw_counter + 1'b1;
                state        <= S_DONE;
              end else begin
                state <= S_ISSUE;
              end
            end
            OP_FILL_RECT: begin
              if (col_inc < end_x) begin
                rect_col <= col_inc;
                state    <= S_ISSUE;
              end else if (row_next < end_y) begin
                rect_row  <= row_next;
                rect_col  <= px;
                rect_mask <= row_mask(row_next, end_y);
                state     <= S_ISSUE;
              end else begin
                draw_counter <= draw_counter + 1'b1;
                state        <= S_DONE;
              end
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/page_framebuffer_draw_engine.sv
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine
// Window set and unknown codes: prepare, then the result. Pixel draw and byte
// read: prepare, issue, modify, then the result, or prepare then the result
// when off the panel; window fill: issue and modify per pixel; rectangle fill:
// issue and modify per page byte. Each page byte drawn on the panel is a read
// then a write through the single frame store port pair; in_ready rises in
// the cycle after the result leaves the sequencer. After reset all 4096 store
// bytes are swept to zero with in_ready low; configuration is taken.
// ----------------------------------------------------------------------------
module page_framebuffer_draw_engine (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [pfde_pkg::RegIdxBits-1:0]  cfg_index,
  input  logic [pfde_pkg::PosXBits-1:0]    cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [pfde_pkg::OpBits-1:0]      operation,
  input  logic [pfde_pkg::PosXBits-1:0]    pos_x,
  input  logic [pfde_pkg::PosYBits-1:0]    pos_y,
  input  logic [pfde_pkg::PosXBits-1:0]    size_w,
  input  logic [pfde_pkg::PosYBits-1:0]    size_h,
  input  logic                             pixel_color,
  input  logic [pfde_pkg::CountBits-1:0]   pixel_count,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [pfde_pkg::DataBits-1:0]    read_byte,
  output logic [pfde_pkg::CountBits-1:0]   update_count
);
  import pfde_pkg::*;

  logic [PosXBits-1:0] panel_width;
  logic [PosYBits-1:0] panel_height;
  pan_t                pan;
  logic                res_valid;
  logic                res_ready;
  res_t                res;
  mem_req_t            mem_req;
  logic [DataBits-1:0] mem_rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_width  <= PosXBits'(128);
      panel_height <= PosYBits'(64);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PANEL_WIDTH:  panel_width  <= cfg_data;
        REG_PANEL_HEIGHT: panel_height <= cfg_data[PosYBits-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (panel_width == '0) begin
      pan.width = PosXBits'(1);
    end else if (panel_width > PosXBits'(MaxWidth)) begin
      pan.width = PosXBits'(MaxWidth);
    end else begin
      pan.width = panel_width;
    end
    if (panel_height == '0) begin
      pan.height = PosYBits'(1);
    end else if (panel_height > PosYBits'(MaxHeight)) begin
      pan.height = PosYBits'(MaxHeight);
    end else begin
      pan.height = panel_height;
    end
  end

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      read_byte    <= res.read_byte;
      update_count <= res.update_count;
    end
  end

  pfde_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .pan         (pan),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .size_w      (size_w),
    .size_h      (size_h),
    .pixel_color (pixel_color),
    .pixel_count (pixel_count),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_req     (mem_req),
    .mem_rd_data (mem_rd_data)
  );

  pfde_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

endmodule

### hdl/pfde_checker.sv
// ----------------------------------------------------------------------------
// pfde_checker
// Port-level checks of the draw engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "page_framebuffer_draw_engine_assert.svh"

module pfde_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] read_byte,
  input logic [15:0] update_count
);

  logic [23:0] out_beat;

  assign out_beat = {read_byte, update_count};

  // A stalled result beat holds its value.
  `PFDE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_beat))
  // One item is worked at a time, so an input beat closes the input side.
  `PFDE_ASSERT_NEXT(a_busy_after_in, clk, rst, in_valid && in_ready, !in_ready)
  // Every item keeps the sequencer busy through its prepare state and the state after it.
  `PFDE_ASSERT_NEXT(a_busy_two, clk, rst, in_valid && in_ready, !in_ready ##1 !in_ready)
  // Reset starts the clearing sweep with both sides closed.
  `PFDE_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, rst, !in_ready && !out_valid)

endmodule

bind page_framebuffer_draw_engine pfde_checker u_checker (.*);

### dv/page_framebuffer_draw_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine_tb
// Self-checking bench for the page framebuffer draw engine. Commands are
// queued up front and driven in random bursts. Result beats are drained
// through a stalling receiver. A shadow framebuffer with its own window,
// cursor and update counter predicts every result, which is compared field
// by field. The panel geometry is changed between phases, including zero,
// minimum, maximum and oversized settings, so that stale windows are hit.
// ----------------------------------------------------------------------------
module page_framebuffer_draw_engine_tb;
  import pfde_pkg::*;

  localparam logic [OpBits-1:0] OP_RESERVED_A = 3'd6;
  localparam logic [OpBits-1:0] OP_RESERVED_B = 3'd7;
  localparam int unsigned PageMask = PageRows - 1;

  typedef enum logic [1:0] {ENT_CMD, ENT_CFG, ENT_DRAIN} entry_kind_t;

  typedef struct packed {
    logic [OpBits-1:0]    opc;
    logic [PosXBits-1:0]  x;
    logic [PosYBits-1:0]  y;
    logic [PosXBits-1:0]  sw;
    logic [PosYBits-1:0]  sh;
    logic                 color;
    logic [CountBits-1:0] count;
  } draw_cmd_t;

  typedef struct {
    entry_kind_t             kind;
    draw_cmd_t               cmd;
    logic [RegIdxBits-1:0]   reg_idx;
    logic [PosXBits-1:0]     reg_val;
  } backlog_entry_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [RegIdxBits-1:0] cfg_index = '0;
  logic [PosXBits-1:0]   cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [OpBits-1:0]     operation = '0;
  logic [PosXBits-1:0]   pos_x = '0;
  logic [PosYBits-1:0]   pos_y = '0;
  logic [PosXBits-1:0]   size_w = '0;
  logic [PosYBits-1:0]   size_h = '0;
  logic                  pixel_color = 1'b0;
  logic [CountBits-1:0]  pixel_count = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [DataBits-1:0]   read_byte;
  logic [CountBits-1:0]  update_count;

  page_framebuffer_draw_engine DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .size_w       (size_w),
    .size_h       (size_h),
    .pixel_color  (pixel_color),
    .pixel_count  (pixel_count),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_byte    (read_byte),
    .update_count (update_count)
  );

  backlog_entry_t cmd_backlog[$];
  res_t           readback_due[$];

  bit          in_taken = 1'b0;
  int          mismatch_count = 0;
  int          results_checked = 0;
  int          op_seen[8];
  int          queued_cmds = 0;
  int          settings_run = 0;
  int unsigned gen_w = 128;
  int unsigned gen_h = 64;
  int unsigned last_x = 0;
  int unsigned last_y = 0;
  int          burst_left = 1;
  int          gap_left = 0;
  logic [15:0] stall_bits = 16'hFFFF;
  int          stall_age = 0;

  // Shadow of the framebuffer, the geometry registers and the drawing state.
  logic [DataBits-1:0]  shadow_fb[StoreDepth];
  logic [PosXBits-1:0]  shadow_w_reg;
  logic [PosYBits-1:0]  shadow_h_reg;
  int unsigned          win_l, win_t, win_r, win_b, cur_x, cur_y;
  logic [CountBits-1:0] op_tally;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic void paint_bits(int unsigned idx, logic [7:0] mask, logic color);
    if (idx >= StoreDepth) return;
    if (color) begin
      shadow_fb[idx] = shadow_fb[idx] | mask;
    end else begin
      shadow_fb[idx] = shadow_fb[idx] & ~mask;
    end
  endfunction

  function automatic void plot(int unsigned x, int unsigned y, logic color);
    int unsigned w;
    w = clamp_dim(shadow_w_reg, MaxWidth);
    if (x >= w || y >= clamp_dim(shadow_h_reg, MaxHeight)) return;
    paint_bits(w * (y >> 3) + x, 8'd1 << (y & PageMask), color);
  endfunction

  function automatic void place_start(int unsigned x, int unsigned y);
    int unsigned w, h;
    w = clamp_dim(shadow_w_reg, MaxWidth);
    h = clamp_dim(shadow_h_reg, MaxHeight);
    if (x > w - 1) x = w - 1;
    if (y > h - 1) y = h - 1;
    win_l = x;
    win_t = y;
    cur_x = x;
    cur_y = y;
  endfunction

  function automatic res_t apply_draw_op(draw_cmd_t c);
    res_t        r;
    int unsigned w, h, ex, ey, lx, ly, pg;
    logic [7:0]  mask;
    bit          skip;
    w = clamp_dim(shadow_w_reg, MaxWidth);
    h = clamp_dim(shadow_h_reg, MaxHeight);
    r.read_byte = '0;
    case (c.opc)
      OP_SET_WINDOW: begin
        place_start(c.x, c.y);
        win_r = (c.sw == 0) ? win_l : win_l + c.sw - 1;
        win_b = (c.sh == 0) ? win_t : win_t + c.sh - 1;
        if (win_r > w - 1) win_r = w - 1;
        if (win_b > h - 1) win_b = h - 1;
      end
      OP_SET_START: begin
        place_start(c.x, c.y);
      end
      OP_FILL_WINDOW: begin
        for (int unsigned n = 0; n < c.count; n++) begin
          plot(cur_x, cur_y, c.color);
          cur_x++;
          if (cur_x > win_r) begin
            cur_x = win_l;
            cur_y++;
            if (cur_y > win_b) cur_y = win_t;
          end
        end
        op_tally++;
      end
      OP_DRAW_PIXEL: begin
        if (c.x < w && c.y < h) begin
          plot(c.x, c.y, c.color);
          op_tally++;
        end
      end
      OP_FILL_RECT: begin
        ex = c.x + c.sw;
        ey = c.y + c.sh;
        skip = 1'b0;
        if (ex > w) begin
          if (c.x > w) skip = 1'b1;
          ex = w;
        end
        if (ey > h) begin
          if (c.y > h) skip = 1'b1;
          ey = h;
        end
        if (!skip) begin
          ly = c.y;
          while (ly < ey) begin
            pg = ly >> 3;
            mask = '0;
            while (ly < ey && (ly >> 3) == pg) begin
              mask = mask | (8'd1 << (ly & PageMask));
              ly++;
            end
            for (lx = c.x; lx < ex; lx++) paint_bits(w * pg + lx, mask, c.color);
          end
          op_tally++;
        end
      end
      OP_READ_BYTE: begin
        if (c.x < w && c.y < h) begin
          if (w * (c.y >> 3) + c.x < StoreDepth) r.read_byte = shadow_fb[w * (c.y >> 3) + c.x];
        end
      end
      default: begin
      end
    endcase
    r.update_count = op_tally;
    return r;
  endfunction

  task automatic push_cmd(logic [OpBits-1:0] opc, int x, int y, int sw, int sh, bit color,
                          int count);
    backlog_entry_t e;
    e.kind = ENT_CMD;
    e.cmd.opc = opc;
    e.cmd.x = x[PosXBits-1:0];
    e.cmd.y = y[PosYBits-1:0];
    e.cmd.sw = sw[PosXBits-1:0];
    e.cmd.sh = sh[PosYBits-1:0];
    e.cmd.color = color;
    e.cmd.count = count[CountBits-1:0];
    e.reg_idx = '0;
    e.reg_val = '0;
    cmd_backlog.push_back(e);
    queued_cmds++;
  endtask

  task automatic push_marker(entry_kind_t kind, logic [RegIdxBits-1:0] idx, int val);
    backlog_entry_t e;
    e.kind = kind;
    e.cmd = '0;
    e.reg_idx = idx;
    e.reg_val = val[PosXBits-1:0];
    cmd_backlog.push_back(e);
    if (kind == ENT_CFG) begin
      if (idx == REG_PANEL_WIDTH) begin
        gen_w = clamp_dim(val & 'h1FF, MaxWidth);
      end else begin
        gen_h = clamp_dim(val & 'hFF, MaxHeight);
      end
    end
  endtask

  task automatic add_random_cmd();
    int sel, x, y, sw, sh, n, r;
    sel = $urandom_range(0, 99);
    if ($urandom_range(0, 5) == 0) begin
      x = $urandom_range(0, 511);
      y = $urandom_range(0, 255);
    end else begin
      x = $urandom_range(0, gen_w);
      y = $urandom_range(0, gen_h);
    end
    sw = $urandom_range(0, 511);
    sh = $urandom_range(0, 255);
    n = $urandom_range(0, 65535);
    if (sel < 10) begin
      // Window set, stream into it, then read back the start byte and the byte a column right and a page down.
      sw = $urandom_range(0, 12);
      sh = $urandom_range(0, 12);
      push_cmd(OP_SET_WINDOW, x, y, sw, sh, $urandom_range(0, 1), n);
      push_cmd(OP_FILL_WINDOW, x, y, sw, sh, $urandom_range(0, 1),
               $urandom_range(0, (sw + 1) * (sh + 1) + 4));
      push_cmd(OP_READ_BYTE, x, y, sw, sh, 1'b0, n);
      push_cmd(OP_READ_BYTE, x + 1, y + 8, sw, sh, 1'b1, n);
    end else if (sel < 20) begin
      if ($urandom_range(0, 2) != 0) begin
        sw = $urandom_range(0, 40);
        sh = $urandom_range(0, 20);
      end
      push_cmd(OP_SET_WINDOW, x, y, sw, sh, $urandom_range(0, 1), n);
    end else if (sel < 26) begin
      push_cmd(OP_SET_START, x, y, sw, sh, $urandom_range(0, 1), n);
    end else if (sel < 42) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        n = $urandom_range(0, 64);
      end else if (r < 97) begin
        n = $urandom_range(0, 600);
      end else begin
        n = $urandom_range(0, 4000);
      end
      push_cmd(OP_FILL_WINDOW, x, y, sw, sh, $urandom_range(0, 1), n);
    end else if (sel < 64) begin
      push_cmd(OP_DRAW_PIXEL, x, y, sw, sh, $urandom_range(0, 1), n);
      last_x = x;
      last_y = y;
    end else if (sel < 76) begin
      if ($urandom_range(0, 9) != 0) begin
        sw = $urandom_range(0, 24);
        sh = $urandom_range(0, 24);
      end
      push_cmd(OP_FILL_RECT, x, y, sw, sh, $urandom_range(0, 1), n);
      last_x = x;
      last_y = y;
    end else if (sel < 95) begin
      if ($urandom_range(0, 1) == 0) begin
        x = last_x;
        y = last_y;
      end
      push_cmd(OP_READ_BYTE, x, y, sw, sh, $urandom_range(0, 1), n);
    end else begin
      push_cmd($urandom_range(0, 1) ? OP_RESERVED_A : OP_RESERVED_B, x, y, sw, sh,
               $urandom_range(0, 1), n);
    end
  endtask

  task automatic run_phase(int width_val, int height_val, int n_cmds);
    int target;
    push_marker(ENT_CFG, REG_PANEL_WIDTH, width_val);
    push_marker(ENT_CFG, REG_PANEL_HEIGHT, height_val);
    settings_run++;
    // Streams through whatever window the previous geometry left behind.
    push_cmd(OP_FILL_WINDOW, 0, 0, 0, 0, 1'b1, 24);
    target = queued_cmds + n_cmds;
    while (queued_cmds < target) begin
      add_random_cmd();
      if (queued_cmds % 97 == 0) push_marker(ENT_DRAIN, '0, 0);
    end
  endtask

  initial begin : build_stimulus
    int wv, hv;
    // Directed checks on the reset geometry of 128 by 64.
    settings_run = 1;
    push_cmd(OP_READ_BYTE, 0, 0, 0, 0, 1'b0, 0);
    push_cmd(OP_DRAW_PIXEL, 0, 0, 0, 0, 1'b1, 0);
    push_cmd(OP_DRAW_PIXEL, 127, 63, 0, 0, 1'b1, 0);
    push_cmd(OP_READ_BYTE, 127, 56, 0, 0, 1'b0, 0);
    push_cmd(OP_DRAW_PIXEL, 128, 0, 0, 0, 1'b1, 0);
    push_cmd(OP_DRAW_PIXEL, 511, 255, 511, 255, 1'b1, 65535);
    push_cmd(OP_SET_WINDOW, 120, 60, 20, 10, 1'b0, 0);
    push_cmd(OP_FILL_WINDOW, 0, 0, 0, 0, 1'b1, 40);
    push_cmd(OP_READ_BYTE, 120, 56, 0, 0, 1'b0, 0);
    push_cmd(OP_SET_WINDOW, 511, 255, 0, 0, 1'b0, 0);
    push_cmd(OP_FILL_WINDOW, 0, 0, 0, 0, 1'b0, 3);
    push_cmd(OP_SET_WINDOW, 100, 40, 4, 4, 1'b0, 0);
    push_cmd(OP_SET_START, 110, 50, 0, 0, 1'b0, 0);
    push_cmd(OP_FILL_WINDOW, 0, 0, 0, 0, 1'b1, 5);
    push_cmd(OP_FILL_WINDOW, 0, 0, 0, 0, 1'b1, 0);
    push_cmd(OP_FILL_RECT, 3, 3, 10, 12, 1'b1, 0);
    push_cmd(OP_READ_BYTE, 5, 8, 0, 0, 1'b0, 0);
    push_cmd(OP_FILL_RECT, 130, 0, 10, 5, 1'b1, 0);
    push_cmd(OP_FILL_RECT, 128, 0, 10, 5, 1'b1, 0);
    push_cmd(OP_FILL_RECT, 0, 70, 4, 4, 1'b1, 0);
    push_cmd(OP_FILL_RECT, 10, 10, 0, 0, 1'b1, 0);
    push_cmd(OP_READ_BYTE, 128, 64, 0, 0, 1'b0, 0);
    push_cmd(OP_RESERVED_A, 7, 9, 3, 2, 1'b1, 12);
    push_cmd(OP_RESERVED_B, 0, 0, 0, 0, 1'b0, 0);
    push_cmd(OP_SET_WINDOW, 0, 0, 128, 64, 1'b0, 0);
    push_cmd(OP_FILL_WINDOW, 0, 0, 0, 0, 1'b1, 32768);
    push_cmd(OP_FILL_RECT, 0, 0, 511, 255, 1'b0, 0);
    push_cmd(OP_READ_BYTE, 64, 32, 0, 0, 1'b0, 0);

    run_phase(256, 128, 200);
    run_phase(1, 1, 50);
    run_phase(0, 0, 50);
    run_phase(511, 'h1FF, 180);
    run_phase(100, 37, 150);
    repeat (3) begin
      case ($urandom_range(0, 9))
        0: wv = 0;
        1: wv = $urandom_range(257, 511);
        default: wv = $urandom_range(1, 256);
      endcase
      case ($urandom_range(0, 9))
        0: hv = 0;
        1: hv = $urandom_range(129, 511);
        default: hv = $urandom_range(1, 128);
      endcase
      run_phase(wv, hv, 140);
    end
    run_phase(128, 64, 150);
  end

  always @(negedge clk) begin : sender
    backlog_entry_t ent;
    logic           valid_next;
    logic           cfg_next;
    valid_next = in_valid && !in_taken;
    cfg_next = 1'b0;
    if (!rst && !valid_next) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (cmd_backlog.size() > 0) begin
        ent = cmd_backlog[0];
        case (ent.kind)
          ENT_CMD: begin
            void'(cmd_backlog.pop_front());
            {operation, pos_x, pos_y, size_w, size_h, pixel_color, pixel_count} <= ent.cmd;
            valid_next = 1'b1;
            if (burst_left > 1) begin
              burst_left--;
            end else begin
              burst_left = $urandom_range(1, 24);
              gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
          end
          ENT_CFG: begin
            if (readback_due.size() == 0) begin
              void'(cmd_backlog.pop_front());
              cfg_index <= ent.reg_idx;
              cfg_data <= ent.reg_val;
              cfg_next = 1'b1;
            end
          end
          default: begin
            if (readback_due.size() == 0) void'(cmd_backlog.pop_front());
          end
        endcase
      end
    end
    in_valid <= valid_next;
    cfg_write <= cfg_next;

    stall_bits = {stall_bits[0], stall_bits[15:1]};
    stall_age++;
    if (stall_age >= 128) begin
      stall_age = 0;
      case ($urandom_range(0, 2))
        0: stall_bits = 16'hFFFF;
        1: stall_bits = 16'($urandom) | 16'h0001;
        default: stall_bits = (16'($urandom) & 16'($urandom)) | 16'h0001;
      endcase
    end
    out_ready <= stall_bits[0];
  end

  always @(posedge clk) begin : result_watch
    res_t      want;
    draw_cmd_t seen;
    in_taken = 1'b0;
    if (rst) begin
      foreach (shadow_fb[i]) shadow_fb[i] = '0;
      shadow_w_reg = 9'd128;
      shadow_h_reg = 8'd64;
      win_l = 0;
      win_t = 0;
      win_r = 0;
      win_b = 0;
      cur_x = 0;
      cur_y = 0;
      op_tally = '0;
    end else begin
      if (out_valid && out_ready) begin
        results_checked++;
        if (readback_due.size() == 0) begin
          $error("result beat with nothing outstanding: read_byte %0d, update_count %0d",
                 read_byte, update_count);
          mismatch_count++;
        end else begin
          want = readback_due.pop_front();
          if (read_byte !== want.read_byte) begin
            $error("read_byte: expected %0d, got %0d", want.read_byte, read_byte);
            mismatch_count++;
          end
          if (update_count !== want.update_count) begin
            $error("update_count: expected %0d, got %0d", want.update_count, update_count);
            mismatch_count++;
          end
        end
      end
      if (cfg_write) begin
        if (cfg_index == REG_PANEL_WIDTH) begin
          shadow_w_reg = cfg_data;
        end else begin
          shadow_h_reg = cfg_data[PosYBits-1:0];
        end
      end
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        seen = {operation, pos_x, pos_y, size_w, size_h, pixel_color, pixel_count};
        readback_due.push_back(apply_draw_op(seen));
        op_seen[seen.opc]++;
      end
    end
  end

  initial begin : finish_run
    @(negedge rst);
    while (cmd_backlog.size() != 0 || in_valid || readback_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Checked %0d results over %0d panel geometries.", results_checked, settings_run);
    $display("Mix: %0d window sets, %0d start moves, %0d window fills, %0d pixels,",
             op_seen[OP_SET_WINDOW], op_seen[OP_SET_START], op_seen[OP_FILL_WINDOW],
             op_seen[OP_DRAW_PIXEL]);
    $display("     %0d rects, %0d reads, %0d reserved codes.",
             op_seen[OP_FILL_RECT], op_seen[OP_READ_BYTE],
             op_seen[OP_RESERVED_A] + op_seen[OP_RESERVED_B]);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #50_000_000;
    $display("Timed out with %0d results outstanding.", readback_due.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
